FILE: design/uws_pkg.sv
// Shared types and codes for the unique word sorter.
`default_nettype none
package uws_pkg;
   typedef enum logic [1:0] {
      ACT_TEXT  = 2'd0,
      ACT_EOL   = 2'd1,
      ACT_FETCH = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      logic [7:0] char_code;
   } item_type;

   localparam logic [7:0] CHAR_A     = 8'd97;
   localparam logic [7:0] CHAR_Z     = 8'd122;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_NL    = 8'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_LEN,
      ST_SCAN_CMP,
      ST_COPY,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FETCH_RD,
      ST_FETCH_LEN,
      ST_FETCH_LET,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

FILE: design/unique_word_sorter.sv
// Unique word sorter: collects the words of a line and lists them sorted.
//
// Input channel req_*: one beat per byte (req_action text), end of line,
// or fetch. Result channel rsp_*: one beat per fetch, giving the next
// listing byte (letters, space between words, newline after the last).
// A word end walks the sorted order list (states SCAN_RD, SCAN_LEN, then
// SCAN_CMP once per letter compared for each stored word), then copies
// letters (one per cycle) and shifts the order list one entry at a time
// (SHIFT_RD, SHIFT_WR); this walk sets the rate at which items are taken.
// A fetch result beat is registered after the states FETCH_RD, FETCH_LEN
// and FETCH_LET, or after ST_OUT when nothing is left to list.
// A four-entry queue buffers requests so the sender keeps going while a
// word is inserted. Reset empties the queue, the word table and the
// overflow flag. When the receiver stalls, the result beat is held and
// no further fetch is started until it is taken.
`default_nettype none
module unique_word_sorter
   import uws_pkg::*;
#(
   parameter int MAX_WORDS   = 256,
   parameter int MAX_LETTERS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_is_last,
   output logic            rsp_is_empty,
   output logic            rsp_overflow
);
   logic     q_valid, q_take;
   item_type q_item;

   uws_front #(.DEPTH(4)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_char_code(req_char_code),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take));

   uws_back #(.MAX_WORDS(MAX_WORDS), .MAX_LETTERS(MAX_LETTERS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_char(rsp_out_char),
      .rsp_is_last(rsp_is_last), .rsp_is_empty(rsp_is_empty),
      .rsp_overflow(rsp_overflow));

   a_last_nl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_out_char == CHAR_NL)
      else $error("last beat is not newline");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_out_char == 8'd0 && !rsp_is_last)
      else $error("empty beat carries data");
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_is_last) && $stable(rsp_is_empty) && $stable(rsp_overflow))
      else $error("stalled beat changed");
endmodule
`default_nettype wire

FILE: design/uws_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module uws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/uws_front.sv
// Front end: accepts items into a short queue.
`default_nettype none
module uws_front
   import uws_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_char_code,
   output logic            q_valid,
   output item_type        q_item,
   input  wire logic       q_take
);
   localparam int AW = $clog2(DEPTH);
   item_type        buf_ff [DEPTH];
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign req_stall = (cnt_ff == AW'(0) + (AW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_take;
   assign q_item    = buf_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + AW'(1) : wp_ff;
      rp_in  = pop ? rp_ff + AW'(1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= item_type'({req_action, req_char_code});
      end
   end
endmodule
`default_nettype wire

FILE: design/uws_back.sv
// Back end: word collection, sorted insert and listing readout.
`default_nettype none
module uws_back
   import uws_pkg::*;
#(
   parameter int MAX_WORDS   = 256,
   parameter int MAX_LETTERS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_valid,
   input  item_type   q_item,
   output logic       q_take,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_is_last,
   output logic       rsp_is_empty,
   output logic       rsp_overflow
);
   localparam int WA = $clog2(MAX_WORDS);
   localparam int WC = $clog2(MAX_WORDS + 1);
   localparam int LA = $clog2(MAX_LETTERS);
   localparam int LC = $clog2(MAX_LETTERS + 1);

   state_type        st_ff, st_in;
   logic [WC-1:0]    count_ff, count_in, pos_ff, pos_in;
   logic [WC-1:0]    rword_ff, rword_in;
   logic [LC-1:0]    plen_ff, plen_in, idx_ff, idx_in, rlet_ff, rlet_in;
   logic [4:0]       pend_ff [MAX_LETTERS];
   logic [WA-1:0]    slot_ff, slot_in;
   logic             ovf_ff, ovf_in, closed_ff, closed_in;
   logic             ovalid_ff, ovalid_in;
   logic [7:0]       ochar_ff, ochar_in;
   logic             olast_ff, olast_in, oempty_ff, oempty_in;
   logic             oovf_ff, oovf_in;

   logic             let_we;
   logic [WA+LA-1:0] let_wa, let_ra;
   logic [4:0]       let_rd;
   logic             len_we;
   logic [LC-1:0]    len_rd;
   logic             ord_we;
   logic [WA-1:0]    ord_wa, ord_ra, ord_wd, ord_rd;
   logic             pend_we;
   logic [7:0]       ch;
   logic             is_letter;

   uws_ram #(.WIDTH(5), .DEPTH(2 ** (WA + LA))) u_letters (
      .clock(clock), .wr_en(let_we), .wr_addr(let_wa), .wr_data(pend_ff[idx_ff[LA-1:0]]),
      .rd_addr(let_ra), .rd_data(let_rd));
   uws_ram #(.WIDTH(LC), .DEPTH(MAX_WORDS)) u_lengths (
      .clock(clock), .wr_en(len_we), .wr_addr(count_ff[WA-1:0]), .wr_data(plen_ff),
      .rd_addr(slot_in), .rd_data(len_rd));
   uws_ram #(.WIDTH(WA), .DEPTH(MAX_WORDS)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(ord_ra), .rd_data(ord_rd));

   assign ch        = q_item.char_code;
   assign is_letter = (q_item.action == ACT_TEXT) && ch >= CHAR_A && ch <= CHAR_Z;
   assign rsp_valid    = ovalid_ff;
   assign rsp_out_char = ochar_ff;
   assign rsp_is_last  = olast_ff;
   assign rsp_is_empty = oempty_ff;
   assign rsp_overflow = oovf_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.action)
                  ACT_TEXT, ACT_EOL: begin
                     if (!is_letter && (closed_ff ? 1'b0 : plen_ff != '0)) begin
                        st_in = ST_SCAN_RD;
                     end
                  end
                  ACT_FETCH: begin
                     if (!(ovalid_ff && rsp_stall)) begin
                        if (closed_ff && rword_ff < count_ff) begin
                           st_in = ST_FETCH_RD;
                        end else begin
                           st_in = ST_OUT;
                        end
                     end
                  end
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_RD:  st_in = (pos_ff < count_ff) ? ST_SCAN_LEN : ST_COPY;
         ST_SCAN_LEN: st_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (idx_ff < plen_ff && idx_ff < len_rd && let_rd == pend_ff[idx_ff[LA-1:0]]) begin
               st_in = ST_SCAN_CMP;
            end else if (idx_ff == plen_ff && idx_ff == len_rd) begin
               st_in = ST_IDLE;
            end else if (idx_ff < len_rd && (idx_ff == plen_ff ||
                         let_rd > pend_ff[idx_ff[LA-1:0]])) begin
               st_in = (count_ff >= WC'(MAX_WORDS)) ? ST_IDLE : ST_COPY;
            end else begin
               st_in = ST_SCAN_RD;
            end
         end
         ST_COPY: begin
            if (count_ff >= WC'(MAX_WORDS)) begin
               st_in = ST_IDLE;
            end else if (idx_ff + LC'(1) >= plen_ff) begin
               st_in = (count_ff > pos_ff) ? ST_SHIFT_RD : ST_SHIFT_WR;
            end
         end
         ST_SHIFT_RD: st_in = ST_SHIFT_WR;
         ST_SHIFT_WR: st_in = (rword_ff > pos_ff) ? ST_SHIFT_RD : ST_IDLE;
         ST_FETCH_RD: st_in = ST_FETCH_LEN;
         ST_FETCH_LEN: st_in = ST_FETCH_LET;
         ST_FETCH_LET: st_in = ST_OUT;
         ST_OUT: st_in = (ovalid_ff && rsp_stall) ? ST_OUT : ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      rword_in  = rword_ff;
      plen_in   = plen_ff;
      idx_in    = idx_ff;
      rlet_in   = rlet_ff;
      slot_in   = slot_ff;
      ovf_in    = ovf_ff;
      closed_in = closed_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      oempty_in = oempty_ff;
      oovf_in   = oovf_ff;
      q_take    = 1'b0;
      pend_we   = 1'b0;
      let_we    = 1'b0;
      let_wa    = {count_ff[WA-1:0], idx_ff[LA-1:0]};
      let_ra    = {slot_ff, idx_ff[LA-1:0]};
      len_we    = 1'b0;
      ord_we    = 1'b0;
      ord_wa    = pos_ff[WA-1:0];
      ord_wd    = ord_rd;
      ord_ra    = pos_ff[WA-1:0];
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid && !(q_item.action == ACT_FETCH && ovalid_ff && rsp_stall)) begin
               q_take = 1'b1;
               if (q_item.action == ACT_TEXT || q_item.action == ACT_EOL) begin
                  if (closed_ff) begin
                     count_in = '0;
                     plen_in  = '0;
                     rword_in = '0;
                     rlet_in  = '0;
                     ovf_in   = 1'b0;
                  end
                  if (is_letter) begin
                     if ((closed_ff ? LC'(0) : plen_ff) < LC'(MAX_LETTERS)) begin
                        pend_we = 1'b1;
                        plen_in = (closed_ff ? LC'(0) : plen_ff) + LC'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  pos_in = '0;
                  if (q_item.action == ACT_EOL) begin
                     closed_in = 1'b1;
                     rword_in  = '0;
                     rlet_in   = '0;
                  end else begin
                     closed_in = 1'b0;
                  end
               end else if (q_item.action == ACT_FETCH) begin
                  oempty_in = !(closed_ff && rword_ff < count_ff);
                  ochar_in  = 8'd0;
                  olast_in  = 1'b0;
                  oovf_in   = ovf_ff;
                  ord_ra    = rword_ff[WA-1:0];
               end
            end
         end
         ST_SCAN_RD: begin
            ord_ra = pos_ff[WA-1:0];
            idx_in = '0;
         end
         ST_SCAN_LEN: begin
            slot_in = ord_rd;
            let_ra  = {ord_rd, {LA{1'b0}}};
         end
         ST_SCAN_CMP: begin
            idx_in = idx_ff;
            if (st_in == ST_SCAN_CMP) begin
               idx_in = idx_ff + LC'(1);
               let_ra = {slot_ff, LA'(idx_ff + LC'(1))};
            end else if (st_in == ST_SCAN_RD) begin
               pos_in = pos_ff + WC'(1);
            end else if (st_in == ST_IDLE) begin
               plen_in = '0;
               ovf_in  = ovf_ff || (count_ff >= WC'(MAX_WORDS) && !(idx_ff == plen_ff
                                    && idx_ff == len_rd));
            end else begin
               idx_in = '0;
            end
         end
         ST_COPY: begin
            if (count_ff >= WC'(MAX_WORDS)) begin
               ovf_in  = 1'b1;
               plen_in = '0;
            end else begin
               let_we = 1'b1;
               idx_in = idx_ff + LC'(1);
               if (st_in != ST_COPY) begin
                  len_we = 1'b1;
                  slot_in = count_ff[WA-1:0];
                  rword_in = count_ff;
               end
            end
         end
         ST_SHIFT_RD: begin
            ord_ra = WA'(rword_ff - WC'(1));
         end
         ST_SHIFT_WR: begin
            ord_we = 1'b1;
            if (rword_ff > pos_ff) begin
               ord_wa   = rword_ff[WA-1:0];
               ord_wd   = ord_rd;
               rword_in = rword_ff - WC'(1);
            end else begin
               ord_wa = pos_ff[WA-1:0];
               ord_wd = count_ff[WA-1:0];
            end
            if (rword_ff <= pos_ff) begin
               count_in = count_ff + WC'(1);
               plen_in  = '0;
               rword_in = '0;
               pos_in   = '0;
            end
         end
         ST_FETCH_RD: begin
            ord_ra = rword_ff[WA-1:0];
         end
         ST_FETCH_LEN: begin
            slot_in = ord_rd;
            let_ra  = {ord_rd, rlet_ff[LA-1:0]};
         end
         ST_FETCH_LET: begin
            ovalid_in = 1'b1;
            oempty_in = 1'b0;
            if (rlet_ff < len_rd && rlet_ff < LC'(MAX_LETTERS)) begin
               ochar_in = {3'b000, let_rd} + CHAR_A;
               olast_in = 1'b0;
               rlet_in  = rlet_ff + LC'(1);
            end else begin
               olast_in = (rword_ff + WC'(1) == count_ff);
               ochar_in = olast_in ? CHAR_NL : CHAR_SPACE;
               rword_in = rword_ff + WC'(1);
               rlet_in  = '0;
            end
         end
         ST_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         count_ff  <= '0;
         pos_ff    <= '0;
         rword_ff  <= '0;
         plen_ff   <= '0;
         idx_ff    <= '0;
         rlet_ff   <= '0;
         ovf_ff    <= 1'b0;
         closed_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         rword_ff  <= rword_in;
         plen_ff   <= plen_in;
         idx_ff    <= idx_in;
         rlet_ff   <= rlet_in;
         ovf_ff    <= ovf_in;
         closed_ff <= closed_in;
         ovalid_ff <= ovalid_in;
      end
      slot_ff   <= slot_in;
      ochar_ff  <= ochar_in;
      olast_ff  <= olast_in;
      oempty_ff <= oempty_in;
      oovf_ff   <= oovf_in;
      if (pend_we) begin
         pend_ff[closed_ff ? LA'(0) : plen_ff[LA-1:0]] <= ch[4:0] - CHAR_A[4:0];
      end
   end
endmodule
`default_nettype wire

FILE: sim/unique_word_sorter_tb.sv
// Testbench for the unique word sorter: directed table plus random lines, checked by a predictor.
`timescale 1ns / 1ps
module unique_word_sorter_tb
   import uws_pkg::*;
();

   localparam int WORD_LIMIT   = 256;
   localparam int LETTER_LIMIT = 32;

   typedef struct {
      logic [7:0] out_char;
      logic       is_last;
      logic       is_empty;
      logic       overflow;
   } listing_beat_type;

   typedef struct {
      action_type action;
      logic [7:0] char_code;
      bit         typed;
      logic [7:0] out_char;
      logic       is_last;
      logic       is_empty;
      logic       overflow;
   } table_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = ACT_NONE;
   logic [7:0] req_char_code = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_is_last;
   logic       rsp_is_empty;
   logic       rsp_overflow;

   unique_word_sorter i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_char_code(req_char_code),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_char(rsp_out_char), .rsp_is_last(rsp_is_last),
      .rsp_is_empty(rsp_is_empty), .rsp_overflow(rsp_overflow)
   );

   // predictor state
   logic [4:0] word_letters [WORD_LIMIT][LETTER_LIMIT];
   int         word_lengths [WORD_LIMIT];
   int         order_list [WORD_LIMIT];
   int         stored_words;
   logic [4:0] partial_letters [LETTER_LIMIT];
   int         partial_length;
   int         list_word;
   int         list_letter;
   bit         overflow_seen;
   bit         line_done;

   listing_beat_type expected_beats [$];
   int  mismatch_count = 0;
   bit  hold_off_done = 0;
   bit  idle_off = 0;
   bit  long_hold_req = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void new_line();
      stored_words = 0;
      partial_length = 0;
      list_word = 0;
      list_letter = 0;
      overflow_seen = 0;
      line_done = 0;
   endfunction

   function automatic int order_vs_slot(int slot);
      int n;
      n = partial_length < word_lengths[slot] ? partial_length : word_lengths[slot];
      for (int i = 0; i < n; i++) begin
         if (partial_letters[i] != word_letters[slot][i])
            return partial_letters[i] < word_letters[slot][i] ? -1 : 1;
      end
      if (partial_length == word_lengths[slot]) return 0;
      return partial_length < word_lengths[slot] ? -1 : 1;
   endfunction

   function automatic void close_word();
      int pos;
      int c;
      c = 1;
      if (partial_length == 0) return;
      for (pos = 0; pos < stored_words; pos++) begin
         c = order_vs_slot(order_list[pos]);
         if (c <= 0) break;
      end
      if (pos < stored_words && c == 0) begin
         partial_length = 0;
         return;
      end
      if (stored_words >= WORD_LIMIT) begin
         overflow_seen = 1;
         partial_length = 0;
         return;
      end
      for (int i = 0; i < partial_length; i++)
         word_letters[stored_words][i] = partial_letters[i];
      word_lengths[stored_words] = partial_length;
      for (int i = stored_words; i > pos; i--)
         order_list[i] = order_list[i - 1];
      order_list[pos] = stored_words;
      stored_words++;
      partial_length = 0;
   endfunction

   function automatic void predict_listing(action_type act, logic [7:0] ch);
      listing_beat_type b;
      int slot;
      if (act == ACT_TEXT || act == ACT_EOL) begin
         if (line_done) new_line();
         if (act == ACT_TEXT && ch >= CHAR_A && ch <= CHAR_Z) begin
            if (partial_length < LETTER_LIMIT) begin
               partial_letters[partial_length] = 5'(ch - CHAR_A);
               partial_length++;
            end else
               overflow_seen = 1;
         end else
            close_word();
         if (act == ACT_EOL) begin
            line_done = 1;
            list_word = 0;
            list_letter = 0;
         end
         return;
      end
      if (act != ACT_FETCH) return;
      b = '{8'd0, 1'b0, 1'b0, 1'b0};
      if (!line_done || list_word >= stored_words)
         b.is_empty = 1;
      else begin
         slot = order_list[list_word];
         if (list_letter < word_lengths[slot]) begin
            b.out_char = 8'(word_letters[slot][list_letter]) + CHAR_A;
            list_letter++;
         end else begin
            if (list_word + 1 == stored_words) begin
               b.out_char = CHAR_NL;
               b.is_last = 1;
            end else
               b.out_char = CHAR_SPACE;
            list_word++;
            list_letter = 0;
         end
      end
      b.overflow = overflow_seen;
      expected_beats.push_back(b);
   endfunction

   task automatic send_beat(action_type act, logic [7:0] ch, bit allow_gap);
      int gap;
      if (allow_gap && !idle_off && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_char_code <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_listing(act, ch);
      @(negedge clock);
   endtask

   task automatic send_text(action_type act, logic [7:0] ch);
      send_beat(act, ch, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_beats.size() != 0);
   endtask

   function automatic logic [7:0] letter_byte(int alphabet);
      return CHAR_A + 8'($urandom_range(0, alphabet - 1));
   endfunction

   // one random line, then fetch until an empty beat or up to words * 4 + 3 fetches
   task automatic random_line(int words, int max_len, int alphabet);
      int len;
      for (int w = 0; w < words; w++) begin
         len = (max_len > 10 && $urandom_range(0, 9) != 0) ? $urandom_range(1, 6)
                                                            : $urandom_range(1, max_len);
         for (int i = 0; i < len; i++) send_text(ACT_TEXT, letter_byte(alphabet));
         if ($urandom_range(0, 7) == 0)
            send_text(ACT_TEXT, 8'($urandom_range(0, 255)));
         else
            send_text(ACT_TEXT, CHAR_SPACE);
         if ($urandom_range(0, 15) == 0) send_text(ACT_FETCH, 8'($urandom));
      end
      send_text(ACT_EOL, 8'($urandom));
      for (int i = 0; i < words * 4 + 3; i++) begin
         send_text(ACT_FETCH, 8'($urandom));
         if (expected_beats.size() != 0 && expected_beats[$].is_empty) break;
      end
   endtask

   table_row_type directed_rows [] = '{
      '{ACT_FETCH, 8'd0,   1, 8'd0,  1'b0, 1'b1, 1'b0},
      '{ACT_NONE,  8'd255, 0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_EOL,   8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd255, 1, 8'd0,  1'b0, 1'b1, 1'b0},
      '{ACT_TEXT,  8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd122, 0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd97,  0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd96,  0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd97,  0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd123, 0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd122, 0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd97,  0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd255, 0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_TEXT,  8'd97,  0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_EOL,   8'd97,  0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   1, 8'd97, 1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   1, 8'd32, 1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   0, 8'd0,  1'b0, 1'b0, 1'b0},
      '{ACT_FETCH, 8'd0,   1, 8'd0,  1'b0, 1'b1, 1'b0}
   };

   // stimulus
   initial begin
      listing_beat_type typed_beat;
      new_line();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[k]) begin
         send_beat(directed_rows[k].action, directed_rows[k].char_code, 1'b0);
         if (directed_rows[k].typed && expected_beats.size() != 0) begin
            typed_beat = '{directed_rows[k].out_char, directed_rows[k].is_last,
                           directed_rows[k].is_empty, directed_rows[k].overflow};
            expected_beats[$] = typed_beat;
         end
      end
      // long word: overflow on truncation
      for (int i = 0; i < 40; i++) send_text(ACT_TEXT, CHAR_Z);
      send_text(ACT_EOL, 8'd0);
      for (int i = 0; i < 36; i++) send_text(ACT_FETCH, 8'd0);
      wait_drained();
      // long receiver hold-off while the queue fills
      long_hold_req = 1;
      random_line(6, 5, 26);
      wait_drained();
      wait (hold_off_done);
      // full table: 260 distinct two-letter words
      for (int w = 0; w < 260; w++) begin
         send_text(ACT_TEXT, CHAR_A + 8'((w / 26) % 26));
         send_text(ACT_TEXT, CHAR_A + 8'(w % 26));
         send_text(ACT_TEXT, CHAR_SPACE);
      end
      send_text(ACT_TEXT, CHAR_A);
      send_text(ACT_EOL, 8'd0);
      for (int i = 0; i < 8; i++) send_text(ACT_FETCH, 8'd0);
      wait_drained();
      for (int n = 0; n < 13; n++) begin
         if (n == 10) begin
            wait_drained();
            idle_off = 1;
         end
         case ($urandom_range(0, 5))
            0: send_text(action_type'($urandom_range(0, 3)), 8'($urandom));
            1: random_line($urandom_range(1, 4), 40, 3);
            default: random_line($urandom_range(0, 8), 12, $urandom_range(2, 26));
         endcase
      end
      wait_drained();
      repeat (50) @(negedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // receiver stall
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_off_done = 1;
            rsp_stall <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else
            rsp_stall <= 1'b0;
      end
   end

   // compare
   always @(posedge clock) begin
      listing_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected beat char=%0d", rsp_out_char);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_out_char !== e.out_char || rsp_is_last !== e.is_last ||
                rsp_is_empty !== e.is_empty || rsp_overflow !== e.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp char=%0d last=%b empty=%b ovf=%b got %0d %b %b %b",
                           e.out_char, e.is_last, e.is_empty, e.overflow,
                           rsp_out_char, rsp_is_last, rsp_is_empty, rsp_overflow);
            end
         end
      end
   end
endmodule
